FILE: src/tave_pkg.sv
`timescale 1ns / 1ps

package tave_pkg;

    localparam int PATTERN_MAX_BYTES = 8;
    localparam int PATTERN_BITS      = PATTERN_MAX_BYTES * 8;
    localparam int MATCH_IDX_BITS    = (PATTERN_MAX_BYTES > 1) ? $clog2(PATTERN_MAX_BYTES) : 1;
    localparam int LENGTH_BITS       = 4;
    localparam int COUNT_BITS        = 16;
    localparam int APB_ADDR_BITS     = 4;
    localparam int APB_DATA_BITS     = 64;

    localparam logic [PATTERN_BITS-1:0] PATTERN_RESET = PATTERN_BITS'(64'd1717924456);
    localparam logic [LENGTH_BITS-1:0]  LENGTH_RESET  = LENGTH_BITS'(4);

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_GT    = 8'h3E;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_AFTER_LT = 8'b0000_0010,
        ST_NAME     = 8'b0000_0100,
        ST_WORD     = 8'b0000_1000,
        ST_MATCHED  = 8'b0001_0000,
        ST_AFTER_EQ = 8'b0010_0000,
        ST_VALUE    = 8'b0100_0000,
        ST_ENDED    = 8'b1000_0000
    } t_scan_state;

    typedef enum logic [2:0] {
        CL_SPACE = 3'd0,
        CL_LT    = 3'd1,
        CL_TAG   = 3'd2,
        CL_EQ    = 3'd3,
        CL_GT    = 3'd4,
        CL_OTHER = 3'd5,
        CL_END   = 3'd6
    } t_char_class;

    typedef enum logic [1:0] {
        OUT_MORE    = 2'd0,
        OUT_LAST    = 2'd1,
        OUT_EMPTY   = 2'd2,
        OUT_ABANDON = 2'd3
    } t_outcome;

    typedef struct packed {
        logic [PATTERN_BITS-1:0] pattern;
        logic [LENGTH_BITS-1:0]  length;
    } t_cfg;

    typedef struct packed {
        logic                  valid;
        logic [7:0]            value_byte;
        t_outcome              outcome;
        logic [COUNT_BITS-1:0] value_number;
    } t_result;

    function automatic t_scan_state next_scan(input t_scan_state st, input t_char_class cls);
        t_scan_state nx;
        nx = ST_ENDED;
        if (cls == CL_END) begin
            nx = ST_ENDED;
        end else if (cls == CL_GT) begin
            nx = ST_IDLE;
        end else begin
            unique case (st)
                ST_IDLE: begin
                    nx = (cls == CL_LT) ? ST_AFTER_LT : ST_IDLE;
                end
                ST_AFTER_LT: begin
                    case (cls) inside
                        CL_SPACE: nx = ST_NAME;
                        CL_OTHER: nx = ST_WORD;
                        default:  nx = ST_AFTER_LT;
                    endcase
                end
                ST_NAME: begin
                    case (cls) inside
                        CL_SPACE:     nx = ST_NAME;
                        CL_TAG:       nx = ST_MATCHED;
                        CL_LT, CL_EQ: nx = ST_AFTER_LT;
                        default:      nx = ST_IDLE;
                    endcase
                end
                ST_WORD: begin
                    case (cls) inside
                        CL_SPACE: nx = ST_NAME;
                        CL_LT:    nx = ST_AFTER_LT;
                        default:  nx = ST_WORD;
                    endcase
                end
                ST_MATCHED: begin
                    case (cls) inside
                        CL_SPACE: nx = ST_MATCHED;
                        CL_LT:    nx = ST_AFTER_LT;
                        CL_EQ:    nx = ST_AFTER_EQ;
                        default:  nx = ST_WORD;
                    endcase
                end
                ST_AFTER_EQ: begin
                    nx = (cls == CL_SPACE) ? ST_AFTER_EQ : ST_VALUE;
                end
                ST_VALUE: begin
                    nx = (cls == CL_SPACE) ? ST_NAME : ST_VALUE;
                end
                default: begin
                    nx = ST_ENDED;
                end
            endcase
        end
        return nx;
    endfunction

endpackage

FILE: src/tave_cfg.sv
`timescale 1ns / 1ps

module tave_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tave_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [tave_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [tave_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output tave_pkg::t_cfg                      o_cfg
);

    tave_pkg::t_cfg r_cfg;
    logic           wr_en;

    // Registers sit at byte addresses 0 and 8, so address bit 3 selects one.
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern <= tave_pkg::PATTERN_RESET;
            r_cfg.length  <= tave_pkg::LENGTH_RESET;
        end else if (wr_en) begin
            if (paddr[3]) begin
                r_cfg.length <= pwdata[tave_pkg::LENGTH_BITS-1:0];
            end else begin
                r_cfg.pattern <= pwdata[tave_pkg::PATTERN_BITS-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[3]) begin
            prdata[tave_pkg::LENGTH_BITS-1:0] = r_cfg.length;
        end else begin
            prdata[tave_pkg::PATTERN_BITS-1:0] = r_cfg.pattern;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/tave_core.sv
`timescale 1ns / 1ps

module tave_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_text_byte,
    input  logic                i_end_of_text,
    input  tave_pkg::t_cfg      i_cfg,
    output tave_pkg::t_result   o_result
);

    localparam int IW = tave_pkg::MATCH_IDX_BITS;
    localparam int CW = tave_pkg::COUNT_BITS;

    tave_pkg::t_scan_state r_state, n_state;
    logic [IW-1:0]         r_match_idx, n_match_idx;
    logic [7:0]            r_held_byte, n_held_byte;
    logic [CW-1:0]         r_value_count, n_value_count;

    tave_pkg::t_char_class cls;
    tave_pkg::t_result     res;
    logic                  is_end;
    logic                  is_match;
    logic [7:0]            pat_byte;
    logic [tave_pkg::LENGTH_BITS-1:0] eff_len;
    logic [tave_pkg::LENGTH_BITS-1:0] idx_next;

    always_comb begin
        if (i_cfg.length == '0) begin
            eff_len = tave_pkg::LENGTH_BITS'(1);
        end else if (i_cfg.length > tave_pkg::LENGTH_BITS'(tave_pkg::PATTERN_MAX_BYTES)) begin
            eff_len = tave_pkg::LENGTH_BITS'(tave_pkg::PATTERN_MAX_BYTES);
        end else begin
            eff_len = i_cfg.length;
        end
    end

    assign pat_byte = i_cfg.pattern[r_match_idx*8 +: 8];
    assign idx_next = tave_pkg::LENGTH_BITS'(r_match_idx) + tave_pkg::LENGTH_BITS'(1);
    assign is_end   = i_end_of_text || (i_text_byte == 8'd0);

    always_comb begin
        if (is_end) begin
            cls = tave_pkg::CL_END;
        end else if (r_state == tave_pkg::ST_NAME && r_match_idx != '0) begin
            cls = tave_pkg::CL_OTHER;
        end else if (i_text_byte == tave_pkg::CHAR_SPACE) begin
            cls = tave_pkg::CL_SPACE;
        end else if (i_text_byte == tave_pkg::CHAR_LT) begin
            cls = tave_pkg::CL_LT;
        end else if (i_text_byte == tave_pkg::CHAR_EQ) begin
            cls = tave_pkg::CL_EQ;
        end else if (i_text_byte == tave_pkg::CHAR_GT) begin
            cls = tave_pkg::CL_GT;
        end else begin
            cls = tave_pkg::CL_OTHER;
        end
    end

    assign is_match = (r_state == tave_pkg::ST_NAME) && (cls == tave_pkg::CL_OTHER)
                      && (i_text_byte == pat_byte);

    always_comb begin
        tave_pkg::t_char_class fcls;
        fcls          = cls;
        n_state       = r_state;
        n_match_idx   = r_match_idx;
        n_held_byte   = r_held_byte;
        n_value_count = r_value_count;
        res           = '0;
        res.outcome   = tave_pkg::OUT_MORE;
        if (r_state != tave_pkg::ST_ENDED) begin
            if (is_match && idx_next < eff_len) begin
                n_match_idx = IW'(idx_next);
            end else begin
                if (is_match) begin
                    fcls = tave_pkg::CL_TAG;
                end
                n_match_idx = '0;
                if (r_state == tave_pkg::ST_AFTER_EQ) begin
                    if (fcls == tave_pkg::CL_GT) begin
                        n_value_count = r_value_count + CW'(1);
                        res.valid     = 1'b1;
                        res.outcome   = tave_pkg::OUT_EMPTY;
                    end else if (fcls != tave_pkg::CL_SPACE && fcls != tave_pkg::CL_END) begin
                        n_held_byte = i_text_byte;
                    end
                end else if (r_state == tave_pkg::ST_VALUE) begin
                    res.valid      = 1'b1;
                    res.value_byte = r_held_byte;
                    if (fcls == tave_pkg::CL_SPACE || fcls == tave_pkg::CL_GT) begin
                        n_value_count = r_value_count + CW'(1);
                        res.outcome   = tave_pkg::OUT_LAST;
                    end else if (fcls == tave_pkg::CL_END) begin
                        res.outcome   = tave_pkg::OUT_ABANDON;
                    end else begin
                        res.outcome   = tave_pkg::OUT_MORE;
                        n_held_byte   = i_text_byte;
                    end
                end
                n_state = tave_pkg::next_scan(r_state, fcls);
            end
        end
        res.value_number = n_value_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tave_pkg::ST_IDLE;
            r_match_idx   <= '0;
            r_held_byte   <= '0;
            r_value_count <= '0;
        end else if (i_fire) begin
            r_state       <= n_state;
            r_match_idx   <= n_match_idx;
            r_held_byte   <= n_held_byte;
            r_value_count <= n_value_count;
        end
    end

    assign o_result = res;

endmodule

FILE: src/tag_attribute_value_extractor.sv
`timescale 1ns / 1ps
// A request is held in the input register and its result is then written to the result
// register. Throughput: one request per cycle while the output is not stalled; the scan
// state is updated between the input register and the result register.
// Reset is synchronous and active low; it clears the scan state, the value count,
// both handshake registers and restores the default pattern and length.

module tag_attribute_value_extractor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [7:0]                          i_text_byte,
    input  logic                                i_end_of_text,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [7:0]                          o_value_byte,
    output logic [1:0]                          o_outcome,
    output logic [15:0]                         o_value_number,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tave_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [tave_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [tave_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    tave_pkg::t_cfg    cfg;
    tave_pkg::t_result result;

    logic       r_in_valid;
    logic [7:0] r_text_byte;
    logic       r_end_of_text;
    logic       fire;

    tave_pkg::t_result r_out;

    assign fire       = r_in_valid && (!r_out.valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_text_byte   <= i_text_byte;
            r_end_of_text <= i_end_of_text;
        end
    end

    tave_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tave_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_text_byte   (r_text_byte),
        .i_end_of_text (r_end_of_text),
        .i_cfg         (cfg),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else if (fire) begin
            r_out <= result;
        end else if (i_out_ready) begin
            r_out.valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out.valid;
    assign o_value_byte   = r_out.value_byte;
    assign o_outcome      = r_out.outcome;
    assign o_value_number = r_out.value_number;

endmodule

FILE: src/tave_checker.sv
`timescale 1ns / 1ps

module tave_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_value_byte,
    input logic [1:0]  o_outcome,
    input logic [15:0] o_value_number
);

    // No result may be pending right after a reset cycle.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_value_byte)
            && $stable(o_outcome) && $stable(o_value_number))
        else $error("stalled result changed");

    // An empty value carries no byte.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_outcome == tave_pkg::OUT_EMPTY |-> o_value_byte == 8'd0)
        else $error("empty value carries a byte");

    // An abandoned value ends the scan, so nothing follows once it is taken.
    a_abandon_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_outcome == tave_pkg::OUT_ABANDON |=> !o_out_valid)
        else $error("result after abandoned value");

    // With no result waiting the block always takes a new request.
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with output free");

endmodule

bind tag_attribute_value_extractor tave_checker u_tave_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_value_byte   (o_value_byte),
    .o_outcome      (o_outcome),
    .o_value_number (o_value_number)
);
